>>> rtl/wcms_pkg.sv
// Shared types, constants and table functions for the weighted cost minimum selector.
package wcms_pkg;

   localparam int NUM_WEIGHTS = 6;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [15:0] WEIGHT_RESET     = 16'd256;   // 1.0 in Q8.8
   localparam logic [15:0] BARRIER_RESET    = 16'hFFFF;
   localparam logic [15:0] STOP_SPEED_RESET = 16'd66;    // roughly 0.001 m/s in Q16.16

   localparam logic [31:0] LN2_Q32   = 32'd2977044472;
   localparam logic [47:0] SCORE_MAX = '1;

   typedef enum logic [2:0] {
      REG_WEIGHT_VELOCITY,
      REG_WEIGHT_ACCELERATION,
      REG_WEIGHT_JERK,
      REG_WEIGHT_POSITION,
      REG_WEIGHT_CURVATURE,
      REG_WEIGHT_SIMILARITY,
      REG_PROB_BARRIER,
      REG_STOP_SPEED_THRESHOLD
   } reg_index_type;

   // weight[i] lines up with register index i
   typedef struct packed {
      logic [NUM_WEIGHTS-1:0][15:0] weight;
      logic [15:0]                  prob_barrier;
      logic [15:0]                  stop_speed_threshold;
   } cfg_type;

   typedef struct packed {
      logic       eligible;   // may be chosen
      logic       clear;      // counted and not colliding
      logic       last;
      logic       stop;
      logic [7:0] index;
   } tag_type;

   typedef struct packed {
      logic [NUM_WEIGHTS-1:0][31:0] cost;
      logic [15:0]                  margin;   // barrier minus probability
      tag_type                      tag;
   } cls_type;

   // ln(1 + j/2^bits) in Q.16, via 24 bits of log2 by repeated squaring
   function automatic logic [15:0] ln_entry(input int unsigned j, input int unsigned bits);
      logic [63:0] y;
      logic [63:0] lg;
      logic [63:0] t;
      y  = (64'(1) << bits) + 64'(j);
      y  = y << (30 - bits);
      lg = '0;
      if (y >= 64'h8000_0000) begin
         lg = 64'(1) << 24;
      end else begin
         for (int i = 0; i < 24; i++) begin
            y  = (y * y) >> 30;
            lg = lg << 1;
            if (y >= 64'h8000_0000) begin
               lg = lg | 64'd1;
               y  = y >> 1;
            end
         end
      end
      t = lg * 64'(LN2_Q32) + (64'(1) << 39);
      return 16'(t >> 40);
   endfunction

   // (k+1)*ln2 in Q.16, rounded
   function automatic logic [20:0] barrier_base(input logic [3:0] k);
      logic [39:0] t;
      t = (40'(k) + 40'd1) * 40'(LN2_Q32) + 40'h8000;
      return 21'(t >> 16);
   endfunction

endpackage

>>> rtl/wcms_if.sv
// Channel interfaces: candidate words in, result words out, register writes.
interface wcms_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] cost_vel;
   logic [31:0] cost_acc;
   logic [31:0] cost_jerk;
   logic [31:0] cost_pos;
   logic [31:0] cost_curv;
   logic [31:0] cost_sim;
   logic        collides;
   logic [15:0] hit_prob;
   logic [31:0] vehicle_speed;
   logic        stop_requested;
   logic        last_candidate;

   modport source (
      output valid, cost_vel, cost_acc, cost_jerk, cost_pos,
             cost_curv, cost_sim, collides, hit_prob,
             vehicle_speed, stop_requested, last_candidate,
      input  ready
   );
   modport sink (
      input  valid, cost_vel, cost_acc, cost_jerk, cost_pos,
             cost_curv, cost_sim, collides, hit_prob,
             vehicle_speed, stop_requested, last_candidate,
      output ready
   );
endinterface

interface wcms_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [7:0]  pick_index;
   logic [47:0] best_score;
   logic        all_collide;
   logic        drive_stop;

   modport source (
      output valid, found, pick_index, best_score, all_collide, drive_stop,
      input  ready
   );
   modport sink (
      input  valid, found, pick_index, best_score, all_collide, drive_stop,
      output ready
   );
endinterface

interface wcms_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/wcms_front.sv
// Front end: accepts candidate words, numbers them and classifies eligibility.
module wcms_front
   import wcms_pkg::*;
#(
   parameter int MAX_CANDIDATES = 256
) (
   input  logic      clock,
   input  logic      reset,
   wcms_req_if.sink  req,
   input  cfg_type   cfg,
   input  logic      q_full,
   output logic      push,
   output cls_type   push_item
);

   localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             valid_ff, valid_in;
   cls_type          item_ff, item_in;
   logic             accept;
   logic             counted;
   logic             speed_low;

   assign req.ready = !valid_ff || !q_full;
   assign accept    = req.valid && req.ready;
   assign push      = valid_ff && !q_full;
   assign push_item = item_ff;

   assign counted   = count_ff < CNT_W'(MAX_CANDIDATES);
   assign speed_low = $signed(req.vehicle_speed) < $signed({16'b0, cfg.stop_speed_threshold});

   always_comb begin
      item_in.cost = {req.cost_sim, req.cost_curv, req.cost_pos,
                      req.cost_jerk, req.cost_acc, req.cost_vel};
      item_in.margin       = cfg.prob_barrier - req.hit_prob;
      item_in.tag.eligible = counted && !req.collides
                             && (req.hit_prob < cfg.prob_barrier);
      item_in.tag.clear    = counted && !req.collides;
      item_in.tag.last     = req.last_candidate;
      item_in.tag.stop     = speed_low || req.stop_requested;
      item_in.tag.index    = 8'(count_ff);

      count_in = count_ff;
      if (accept) begin
         if (req.last_candidate) begin
            count_in = '0;
         end else if (counted) begin
            count_in = count_ff + CNT_W'(1);
         end
      end

      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

>>> rtl/wcms_queue.sv
// Short register queue between the front end and the scoring back end.
module wcms_queue
   import wcms_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cls_type push_item,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cls_type pop_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cls_type          store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   assign full      = fill_ff == CNT_W'(QUEUE_DEPTH);
   assign not_empty = fill_ff != '0;
   assign pop_item  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/wcms_back.sv
// Back end: scoring pipeline, running minimum and the result register.
module wcms_back
   import wcms_pkg::*;
#(
   parameter int LOG_TABLE_BITS = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_valid,
   input  cls_type    q_item,
   output logic       pop,
   wcms_rsp_if.source rsp
);

   localparam int TB       = LOG_TABLE_BITS;
   localparam int TBL_SIZE = (1 << TB) + 1;
   localparam int FS       = 15 - TB;

   // ln(1+f) table, constant logic
   logic [15:0] ln_tbl [TBL_SIZE];
   for (genvar g = 0; g < TBL_SIZE; g++) begin : g_tbl
      assign ln_tbl[g] = ln_entry(g, TB);
   end

   logic en;

   // stage 1: products, normalise margin, table lookup
   logic                         v1_ff;
   logic [NUM_WEIGHTS-1:0][47:0] prod1_ff, prod1_in;
   logic [3:0]                   k1_ff, k1_in;
   logic [15:0]                  lo1_ff, lo1_in;
   logic [15:0]                  diff1_ff, diff1_in;
   logic [FS-1:0]                rem1_ff, rem1_in;
   tag_type                      tag1_ff;
   logic [15:0]                  norm;
   logic [TB:0]                  j_lo, j_hi;

   // stage 2: pair sums, interpolation
   logic                v2_ff;
   logic [2:0][48:0]    pair2_ff, pair2_in;
   logic [20:0]         base2_ff;
   logic [16:0]         lop2_ff, lop2_in;
   logic [15+FS:0]      interp;
   tag_type             tag2_ff;

   // stage 3: total and barrier term
   logic        v3_ff;
   logic [50:0] total3_ff, total3_in;
   logic [20:0] bterm3_ff, bterm3_in;
   tag_type     tag3_ff;

   // stage 4: saturated score
   logic        v4_ff;
   logic [47:0] score4_ff, score4_in;
   logic [51:0] score_wide;
   tag_type     tag4_ff;

   // running minimum
   logic [47:0] best_score_ff, best_score_in;
   logic [7:0]  best_index_ff, best_index_in;
   logic        have_ff, have_in;
   logic        clear_ff, clear_in;
   logic        upd;
   logic        adv;
   logic        fin;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        found_ff;
   logic [7:0]  index_ff;
   logic [47:0] score_ff;
   logic        all_collide_ff;
   logic        drive_stop_ff;

   // only a finished set waiting on a full result register holds the pipe
   assign en  = !(v4_ff && tag4_ff.last && rsp_valid_ff && !rsp.ready);
   assign pop = en && q_valid;

   always_comb begin
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
         prod1_in[i] = 48'(cfg.weight[i]) * 48'(q_item.cost[i]);
      end
      k1_in = '0;
      for (int i = 0; i < 16; i++) begin
         if (q_item.margin[i]) begin
            k1_in = 4'(15 - i);
         end
      end
      norm     = q_item.margin << k1_in;
      j_lo     = (TB+1)'(norm[14:FS]);
      j_hi     = j_lo + (TB+1)'(1);
      lo1_in   = ln_tbl[j_lo];
      diff1_in = ln_tbl[j_hi] - ln_tbl[j_lo];
      rem1_in  = norm[FS-1:0];
   end

   always_comb begin
      interp = (16+FS)'(diff1_ff) * (16+FS)'(rem1_ff);
      for (int i = 0; i < 3; i++) begin
         pair2_in[i] = 49'(prod1_ff[2*i]) + 49'(prod1_ff[2*i+1]);
      end
      lop2_in = 17'(lo1_ff) + 17'(interp >> FS);
   end

   always_comb begin
      total3_in = 51'(pair2_ff[0]) + 51'(pair2_ff[1]) + 51'(pair2_ff[2]);
      bterm3_in = base2_ff - 21'(lop2_ff);
   end

   always_comb begin
      score_wide = 52'(total3_ff[50:8]) + 52'(bterm3_ff);
      score4_in  = (score_wide[51:48] != '0) ? SCORE_MAX : score_wide[47:0];
   end

   always_comb begin
      upd = tag4_ff.eligible && (!have_ff || score4_ff < best_score_ff);
      adv = en && v4_ff;
      fin = adv && tag4_ff.last;

      have_in       = have_ff || upd;
      best_score_in = upd ? score4_ff : best_score_ff;
      best_index_in = upd ? tag4_ff.index : best_index_ff;
      clear_in      = clear_ff || tag4_ff.clear;

      rsp_valid_in = rsp_valid_ff;
      if (fin) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         best_score_ff <= SCORE_MAX;
         best_index_ff <= '0;
         have_ff       <= 1'b0;
         clear_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (en) begin
            v1_ff <= pop;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
            v4_ff <= v3_ff;
         end
         if (fin) begin
            best_score_ff <= SCORE_MAX;
            best_index_ff <= '0;
            have_ff       <= 1'b0;
            clear_ff      <= 1'b0;
         end else if (adv) begin
            best_score_ff <= best_score_in;
            best_index_ff <= best_index_in;
            have_ff       <= have_in;
            clear_ff      <= clear_in;
         end
      end

      if (en) begin
         prod1_ff  <= prod1_in;
         k1_ff     <= k1_in;
         lo1_ff    <= lo1_in;
         diff1_ff  <= diff1_in;
         rem1_ff   <= rem1_in;
         tag1_ff   <= q_item.tag;
         pair2_ff  <= pair2_in;
         base2_ff  <= barrier_base(k1_ff);
         lop2_ff   <= lop2_in;
         tag2_ff   <= tag1_ff;
         total3_ff <= total3_in;
         bterm3_ff <= bterm3_in;
         tag3_ff   <= tag2_ff;
         score4_ff <= score4_in;
         tag4_ff   <= tag3_ff;
      end

      if (fin) begin
         found_ff       <= have_in;
         index_ff       <= have_in ? best_index_in : '0;
         score_ff       <= have_in ? best_score_in : '0;
         all_collide_ff <= !clear_in;
         drive_stop_ff  <= tag4_ff.stop;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.found       = found_ff;
   assign rsp.pick_index  = index_ff;
   assign rsp.best_score  = score_ff;
   assign rsp.all_collide = all_collide_ff;
   assign rsp.drive_stop  = drive_stop_ff;

endmodule

>>> rtl/weighted_cost_min_selector.sv
// Top level: weighted cost minimum selector with register bank, front end, queue and back end.
//
// Candidates arrive one word per cycle on req_ch (valid/ready) while ready is high. Each word
// carries six cost terms, a collision flag and probability; the word flagged last_candidate
// closes the set, and its vehicle speed and stop request set the stop flag. One result word
// leaves on rsp_ch per set: found flag, index and score of the cheapest eligible candidate,
// all-collide and stop flags.
// Throughput is one candidate per cycle while the queue has room. rsp_ch valid rises once the
// last candidate passes the front-end register, queue, four scoring stages and result register.
// csr_ch writes the eight registers (weights, barrier, stop threshold) and is always
// ready; write it only while no set is in flight.
// Reset restores register defaults and empties front end, queue and pipeline.
// A stalled rsp_ch holds only once a second finished set reaches the end of the
// scoring pipe; the queue then fills and req_ch ready drops, nothing is dropped.
module weighted_cost_min_selector
   import wcms_pkg::*;
#(
   parameter int MAX_CANDIDATES = 256,
   parameter int LOG_TABLE_BITS = 6
) (
   input  logic       clock,
   input  logic       reset,
   wcms_req_if.sink   req_ch,
   wcms_rsp_if.source rsp_ch,
   wcms_csr_if.sink   csr_ch
);

   cfg_type cfg_ff, cfg_in;
   logic    q_full;
   logic    q_not_empty;
   logic    push;
   logic    pop;
   cls_type push_item;
   cls_type pop_item;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (reg_index_type'(csr_ch.index))
            REG_WEIGHT_VELOCITY:      cfg_in.weight[0]            = csr_ch.data;
            REG_WEIGHT_ACCELERATION:  cfg_in.weight[1]            = csr_ch.data;
            REG_WEIGHT_JERK:          cfg_in.weight[2]            = csr_ch.data;
            REG_WEIGHT_POSITION:      cfg_in.weight[3]            = csr_ch.data;
            REG_WEIGHT_CURVATURE:     cfg_in.weight[4]            = csr_ch.data;
            REG_WEIGHT_SIMILARITY:    cfg_in.weight[5]            = csr_ch.data;
            REG_PROB_BARRIER:         cfg_in.prob_barrier         = csr_ch.data;
            REG_STOP_SPEED_THRESHOLD: cfg_in.stop_speed_threshold = csr_ch.data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WEIGHTS; i++) begin
            cfg_ff.weight[i] <= WEIGHT_RESET;
         end
         cfg_ff.prob_barrier         <= BARRIER_RESET;
         cfg_ff.stop_speed_threshold <= STOP_SPEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wcms_front #(
      .MAX_CANDIDATES (MAX_CANDIDATES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item)
   );

   wcms_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .pop_item  (pop_item)
   );

   wcms_back #(
      .LOG_TABLE_BITS (LOG_TABLE_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_not_empty),
      .q_item  (pop_item),
      .pop     (pop),
      .rsp     (rsp_ch)
   );

endmodule
